/* hdl/quadtree_grid_pixel_render_defines.svh */
// assertion macros of the checker file of the quadtree grid renderer
// no dependencies; the including module must have clk_i and rst_ni in scope
`ifndef QUADTREE_GRID_PIXEL_RENDER_DEFINES_SVH
`define QUADTREE_GRID_PIXEL_RENDER_DEFINES_SVH

// checked only outside reset
`define QGPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define QGPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/qgpr_pkg.sv */
// shared types and constants of the quadtree grid pixel renderer
// no dependencies
package qgpr_pkg;

  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned NODE_W  = 17;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned GREY_W  = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;
  localparam logic [GREY_W-1:0]  GREY_HI     = 8'd255;
  localparam logic [GREY_W-1:0]  GREY_LO     = 8'd0;

  // register index as seen on paddr[2]
  localparam logic REG_TREE_LEVEL = 1'b0;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  // control that travels with each item down the level pipeline
  typedef struct packed {
    logic               vld;
    logic               pix;
    logic               done;
    logic               grey;
    logic               leaf;
    logic [LEVEL_W-1:0] lvl;
    logic               wr;
    logic [LEVEL_W-1:0] wlvl;
    logic               wflag;
  } ctl_t;

  // heap index of the first node at depth d
  function automatic int unsigned lvl_first(int unsigned d);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < d; i++) begin
      acc = acc * 4 + 1;
    end
    return acc;
  endfunction

endpackage

/* hdl/qgpr_in_if.sv */
// input channel of the quadtree grid renderer: handshake plus item fields
// depends on qgpr_pkg
interface qgpr_in_if import qgpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [NODE_W-1:0]  node_index;
  logic               flag_value;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (output valid, cmd, node_index, flag_value, row, col, input ready);
  modport sink   (input valid, cmd, node_index, flag_value, row, col, output ready);
  modport mon    (input valid, ready, cmd, node_index, flag_value, row, col);
endinterface

/* hdl/qgpr_out_if.sv */
// result channel of the quadtree grid renderer: handshake plus grey value
// depends on qgpr_pkg
interface qgpr_out_if import qgpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] grey_value;

  modport source (output valid, grey_value, input ready);
  modport sink   (input valid, grey_value, output ready);
  modport mon    (input valid, ready, grey_value);
endinterface

/* hdl/qgpr_ram.sv */
// generic single-port ram with registered read
// no dependencies
module qgpr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/qgpr_entry.sv */
// entry stage: saturates the level, aligns coordinates, decodes write targets
// depends on qgpr_pkg
module qgpr_entry import qgpr_pkg::*; #(
  parameter int unsigned MAX_LEVEL = 8,
  localparam int unsigned OFF_W    = (MAX_LEVEL > 1) ? 2 * (MAX_LEVEL - 1) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic               cmd_i,
  input  logic [NODE_W-1:0]  node_index_i,
  input  logic               flag_value_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [LEVEL_W-1:0] tree_level_i,
  output ctl_t               ctl_o,
  output logic [MAX_LEVEL-1:0] rs_o,
  output logic [MAX_LEVEL-1:0] cs_o,
  output logic [OFF_W-1:0]   waddr_o
);

  localparam int unsigned XW = MAX_LEVEL + COORD_W;

  logic [LEVEL_W-1:0]   lvl;
  logic [COORD_W-1:0]   rm;
  logic [COORD_W-1:0]   cm;
  logic [XW-1:0]        rx;
  logic [XW-1:0]        cx;
  logic [31:0]          node_ext;
  ctl_t                 ctl_d;
  ctl_t                 ctl_q;
  logic [OFF_W-1:0]     waddr_d;
  logic [OFF_W-1:0]     waddr_q;
  logic [MAX_LEVEL-1:0] rs_q;
  logic [MAX_LEVEL-1:0] cs_q;

  assign lvl = (tree_level_i > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : tree_level_i;

  always_comb begin
    for (int unsigned i = 0; i < COORD_W; i++) begin
      rm[i] = row_i[i] & (LEVEL_W'(i) < lvl);
      cm[i] = col_i[i] & (LEVEL_W'(i) < lvl);
    end
  end

  // top coordinate bit of the walk lands on bit MAX_LEVEL-1
  assign rx = XW'(rm) << (LEVEL_W'(MAX_LEVEL) - lvl);
  assign cx = XW'(cm) << (LEVEL_W'(MAX_LEVEL) - lvl);

  assign node_ext = 32'(node_index_i);

  always_comb begin
    ctl_d       = '0;
    waddr_d     = '0;
    ctl_d.vld   = valid_i;
    ctl_d.pix   = (cmd_i == CMD_PIXEL);
    ctl_d.lvl   = lvl;
    ctl_d.wflag = flag_value_i;
    // leaf parity: the last step lands on an odd node when both bits match
    ctl_d.leaf  = (lvl == '0) ? 1'b1 : (rm[0] ^ cm[0]);
    // flags of the deepest level never decide a pixel, so they are not kept
    if (cmd_i == CMD_WRITE) begin
      for (int unsigned d = 0; d < MAX_LEVEL; d++) begin
        if (node_ext >= lvl_first(d) && node_ext < lvl_first(d + 1)) begin
          ctl_d.wr   = 1'b1;
          ctl_d.wlvl = LEVEL_W'(d);
          waddr_d    = OFF_W'(node_ext - lvl_first(d));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rs_q    <= rx[MAX_LEVEL-1:0];
      cs_q    <= cx[MAX_LEVEL-1:0];
      waddr_q <= waddr_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign rs_o    = rs_q;
  assign cs_o    = cs_q;
  assign waddr_o = waddr_q;

endmodule

/* hdl/qgpr_stage.sv */
// one tree depth of the walk: flag memory of that depth plus its pipeline register
// depends on qgpr_pkg and qgpr_ram
module qgpr_stage import qgpr_pkg::*; #(
  parameter int unsigned MAX_LEVEL = 8,
  parameter int unsigned STAGE     = 0,
  localparam int unsigned OFF_W    = (MAX_LEVEL > 1) ? 2 * (MAX_LEVEL - 1) : 1,
  localparam int unsigned AW       = (STAGE > 0) ? 2 * STAGE : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  ctl_t                 ctl_i,
  input  logic [MAX_LEVEL-1:0] rs_i,
  input  logic [MAX_LEVEL-1:0] cs_i,
  input  logic [OFF_W-1:0]     waddr_i,
  output ctl_t                 ctl_o,
  output logic [MAX_LEVEL-1:0] rs_o,
  output logic [MAX_LEVEL-1:0] cs_o,
  output logic [OFF_W-1:0]     waddr_o
);

  logic [AW-1:0]        raddr;
  logic [AW-1:0]        addr;
  logic                 wr_here;
  logic                 we;
  logic                 re;
  logic                 flag;
  logic                 on_border;
  ctl_t                 ctl_q;
  logic [MAX_LEVEL-1:0] rs_q;
  logic [MAX_LEVEL-1:0] cs_q;
  logic [OFF_W-1:0]     waddr_q;

  // offset within this depth: one quadrant digit per level above it
  always_comb begin
    raddr = '0;
    for (int unsigned j = 0; j < STAGE; j++) begin
      raddr[2*(STAGE-1-j)+1] = rs_i[MAX_LEVEL-1-j];
      raddr[2*(STAGE-1-j)]   = rs_i[MAX_LEVEL-1-j] ^ cs_i[MAX_LEVEL-1-j];
    end
  end

  assign wr_here = ctl_i.vld & ctl_i.wr & (ctl_i.wlvl == LEVEL_W'(STAGE));
  assign we      = adv_i & wr_here;
  assign re      = adv_i & ctl_i.vld & ctl_i.pix;
  assign addr    = wr_here ? waddr_i[AW-1:0] : raddr;

  qgpr_ram #(
    .WIDTH (1),
    .DEPTH (1 << (2 * STAGE))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (ctl_i.wflag),
    .rdata_o (flag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rs_q    <= rs_i;
      cs_q    <= cs_i;
      waddr_q <= waddr_i;
    end
  end

  // top row or left column of the uniform block below this depth
  assign on_border = (rs_q[MAX_LEVEL-1-STAGE:0] == '0) || (cs_q[MAX_LEVEL-1-STAGE:0] == '0);

  always_comb begin
    ctl_o = ctl_q;
    if (ctl_q.vld && ctl_q.pix && !ctl_q.done && (ctl_q.lvl > LEVEL_W'(STAGE)) && flag) begin
      ctl_o.done = 1'b1;
      ctl_o.grey = !on_border;
    end
  end

  assign rs_o    = rs_q;
  assign cs_o    = cs_q;
  assign waddr_o = waddr_q;

endmodule

/* hdl/quadtree_grid_pixel_render.sv */
// quadtree grid pixel renderer, top level; uses qgpr_pkg, the channel interfaces,
// qgpr_entry and one qgpr_stage (with its own flag ram) per tree depth.
// items pass the entry stage, the depth stages and the output register in order; one item per cycle,
// set by the per-depth flag rams that each serve one item a cycle; a stalled output freezes all
// reset clears the pipeline valid bits and the output valid and sets tree_level to 8;
// flag memories are not cleared and hold garbage until written
module quadtree_grid_pixel_render import qgpr_pkg::*; #(
  parameter int unsigned MAX_LEVEL = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qgpr_in_if.sink     in_ch,
  qgpr_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OFF_W = (MAX_LEVEL > 1) ? 2 * (MAX_LEVEL - 1) : 1;

  logic               adv;
  logic [LEVEL_W-1:0] tree_level_q;
  logic               out_vld_q;
  logic               out_vld_d;
  logic [GREY_W-1:0]  grey_q;
  logic [GREY_W-1:0]  grey_d;

  ctl_t                 ctl   [MAX_LEVEL+1];
  logic [MAX_LEVEL-1:0] rs    [MAX_LEVEL];
  logic [MAX_LEVEL-1:0] cs    [MAX_LEVEL];
  logic [OFF_W-1:0]     waddr [MAX_LEVEL];

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TREE_LEVEL) ? 32'(tree_level_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_level_q <= LEVEL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TREE_LEVEL)) begin
      tree_level_q <= pwdata[LEVEL_W-1:0];
    end
  end

  assign adv         = !out_vld_q || out_ch.ready;
  assign in_ch.ready = adv;

  qgpr_entry #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_ch.valid),
    .cmd_i        (in_ch.cmd),
    .node_index_i (in_ch.node_index),
    .flag_value_i (in_ch.flag_value),
    .row_i        (in_ch.row),
    .col_i        (in_ch.col),
    .tree_level_i (tree_level_q),
    .ctl_o        (ctl[0]),
    .rs_o         (rs[0]),
    .cs_o         (cs[0]),
    .waddr_o      (waddr[0])
  );

  for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_lvl
    if (k == MAX_LEVEL - 1) begin : g_last
      qgpr_stage #(
        .MAX_LEVEL (MAX_LEVEL),
        .STAGE     (k)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .ctl_i   (ctl[k]),
        .rs_i    (rs[k]),
        .cs_i    (cs[k]),
        .waddr_i (waddr[k]),
        .ctl_o   (ctl[k+1]),
        .rs_o    (),
        .cs_o    (),
        .waddr_o ()
      );
    end else begin : g_mid
      qgpr_stage #(
        .MAX_LEVEL (MAX_LEVEL),
        .STAGE     (k)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .ctl_i   (ctl[k]),
        .rs_i    (rs[k]),
        .cs_i    (cs[k]),
        .waddr_i (waddr[k]),
        .ctl_o   (ctl[k+1]),
        .rs_o    (rs[k+1]),
        .cs_o    (cs[k+1]),
        .waddr_o (waddr[k+1])
      );
    end
  end

  // a uniform block found on the way down sets the grey; if none was found, the leaf parity decides
  assign out_vld_d = ctl[MAX_LEVEL].vld & ctl[MAX_LEVEL].pix;
  assign grey_d    = (ctl[MAX_LEVEL].done ? ctl[MAX_LEVEL].grey : ctl[MAX_LEVEL].leaf) ?
                     GREY_HI : GREY_LO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grey_q <= grey_d;
    end
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.grey_value = grey_q;

endmodule

/* hdl/qgpr_checker.sv */
// port-level checks of the quadtree grid renderer, bound to the top level
// depends on qgpr_pkg and the defines header; the bind reaches the channel interfaces of the top level
`include "quadtree_grid_pixel_render_defines.svh"

module qgpr_checker import qgpr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [GREY_W-1:0] grey_value,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata
);

  logic lvl_sel;
  logic lvl_wr;

  assign lvl_sel = (paddr[2] == REG_TREE_LEVEL);
  assign lvl_wr  = psel && penable && pwrite && lvl_sel;

  // input side only stalls when a result is held back
  `QGPR_ASSERT_ALWAYS(a_ready_follows_out, in_ready == (!out_valid || out_ready), "bad ready")

  `QGPR_ASSERT(a_grey_levels, out_valid |-> (grey_value == GREY_HI || grey_value == GREY_LO), "bad grey")

  `QGPR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(grey_value), "result lost")

  `QGPR_ASSERT(a_level_readback, lvl_wr |=> !lvl_sel || (prdata[3:0] == $past(pwdata[3:0])), "bad level")

endmodule

bind quadtree_grid_pixel_render qgpr_checker u_qgpr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .grey_value (out_ch.grey_value),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
